>>> rtl/lpc_residual_filter_core_defines.svh
// Assertion macros shared by the residual filter RTL.
`ifndef LPC_RESIDUAL_FILTER_CORE_DEFINES_SVH
`define LPC_RESIDUAL_FILTER_CORE_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define LPCRF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lpc residual filter check failed");

// Clocked check that also holds while reset is asserted.
`define LPCRF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("lpc residual filter check failed during reset");

`endif

>>> rtl/lpcrf_pkg.sv
package lpcrf_pkg;

  localparam int unsigned DataW          = 32;
  localparam int unsigned ProdW          = 2 * DataW;
  localparam int unsigned OpW            = 2;
  localparam int unsigned IdxW           = 5;
  localparam int unsigned TapsDef        = 16;
  localparam int unsigned CoefFracBitsDef = 24;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_FILTER = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_SUM,
    ST_RETIRE
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic [IdxW-1:0]         coef_index;
    logic signed [DataW-1:0] value;
    logic                    frame_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0] residual;
    logic                    last_of_frame;
  } out_beat_t;

endpackage

>>> rtl/lpc_residual_filter_core.sv
// LPC analysis (residual) filter with one shared multiply-accumulate unit.
//
// Input beats arrive on in_valid_i / in_ready_o carrying an operation code, a
// tap number, a 32-bit value and a frame-end flag. A load beat writes one Q24
// coefficient (taps 1 to TAPS, other tap numbers are ignored), a push beat
// shifts a history sample into the delay line, and a filter beat produces one
// residual beat on out_valid_o / out_ready_i. Load and push beats, and beats
// with the unused operation code, finish in the cycle they are accepted and
// produce no result.
//
// A filter beat walks the taps through a single 32 x 32 multiplier, one tap
// per cycle, followed by a sum step for the final addition and a retire step
// that loads the output register. No further input beat is accepted until the
// retire step has finished, so one filter beat is worked on at a time.
// The output register decouples the two sides: a new input beat is accepted
// while a finished residual waits. If the receiver stalls, a following filter
// beat holds in its retire step until the output register is free. Reset
// clears the coefficients and the delay line and empties the output register.
`include "lpc_residual_filter_core_defines.svh"

module lpc_residual_filter_core
  import lpcrf_pkg::*;
#(
  parameter int unsigned TAPS           = TapsDef,
  parameter int unsigned COEF_FRAC_BITS = CoefFracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  // Width of the tap counter; at least one bit so a single-tap build works.
  localparam int unsigned CntW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CntW-1:0] LastTap = CntW'(TAPS - 1);

  state_e state_q, state_d;

  logic [CntW-1:0]         cnt_q;
  logic signed [DataW-1:0] coef_q [TAPS];
  logic signed [DataW-1:0] samp_q [TAPS];
  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic [DataW-1:0]        acc_q;
  logic signed [DataW-1:0] x_q;
  logic                    fe_q;
  logic                    out_valid_q;
  out_beat_t               out_q;

  logic in_fire;
  logic out_free;
  logic mac_issue;
  logic retire;
  logic load_ok;
  logic [IdxW-1:0] load_idx;
  op_e  op;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign op       = op_e'(in_data_i.operation);

  // A load only lands when the tap number lies in 1..TAPS.
  assign load_ok  = (in_data_i.coef_index != '0) &&
                    ({1'b0, in_data_i.coef_index} <= (IdxW+1)'(TAPS));
  assign load_idx = IdxW'(in_data_i.coef_index - IdxW'(1));

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (op == OP_FILTER)) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt_q == LastTap) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        state_d = ST_RETIRE;
      end
      ST_RETIRE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    mac_issue  = 1'b0;
    retire     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_MAC: begin
        mac_issue = 1'b1;
      end
      ST_SUM: begin
        mac_issue = 1'b0;
      end
      ST_RETIRE: begin
        retire = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      prod_vld_q <= mac_issue;
      if (mac_issue) begin
        cnt_q <= cnt_q + CntW'(1);
      end else begin
        cnt_q <= '0;
      end
      if (retire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Coefficient bank and delay line both come out of reset at zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < TAPS; k++) begin
        coef_q[k] <= '0;
        samp_q[k] <= '0;
      end
    end else begin
      if (in_fire && (op == OP_LOAD) && load_ok) begin
        coef_q[load_idx[CntW-1:0]] <= in_data_i.value;
      end
      if ((in_fire && (op == OP_PUSH)) || retire) begin
        for (int unsigned k = TAPS - 1; k > 0; k--) begin
          samp_q[k] <= samp_q[k-1];
        end
        samp_q[0] <= (retire) ? x_q : in_data_i.value;
      end
    end
  end

  // Shared multiplier, registered, then the scaled product is accumulated in
  // the following cycle. Taking bits above the fraction point of the exact
  // product is the arithmetic shift followed by truncation to 32 bits.
  always_ff @(posedge clk_i) begin
    prod_q <= coef_q[cnt_q] * samp_q[cnt_q];
    if (in_fire && (op == OP_FILTER)) begin
      acc_q <= in_data_i.value;
      x_q   <= in_data_i.value;
      fe_q  <= in_data_i.frame_end;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + prod_q[COEF_FRAC_BITS +: DataW];
    end
    if (retire) begin
      out_q.residual      <= acc_q;
      out_q.last_of_frame <= fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LPCRF_ASSERT(a_filter_starts_walk,
    (in_fire && (op == OP_FILTER)) |=> (state_q == ST_MAC) && (cnt_q == '0))
  `LPCRF_ASSERT(a_walk_ends_in_sum,
    ((state_q == ST_MAC) && (cnt_q == LastTap)) |=> (state_q == ST_SUM))
  `LPCRF_ASSERT(a_sum_one_cycle,
    (state_q == ST_SUM) |=> (state_q == ST_RETIRE))
  `LPCRF_ASSERT(a_result_from_retire,
    $rose(out_valid_q) |-> ($past(state_q) == ST_RETIRE))
  `LPCRF_ASSERT(a_push_enters_line,
    (in_fire && (op == OP_PUSH)) |=> (samp_q[0] == $past(in_data_i.value)))
  `LPCRF_ASSERT_ALWAYS(a_reset_empties_output,
    !rst_ni |=> !out_valid_o && in_ready_o)

endmodule

>>> test/lpc_residual_filter_core_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the order-16 residual filter.
//
// An initial block queues input beats: first a short directed run over the
// extremes and the ignored cases, then phases of random frames. Each frame
// loads some coefficients, pushes some history and filters a run of samples,
// with noise beats mixed in. A driver process offers the queued beats with
// random gaps. A receiver process stalls the result side at random, once for a
// long stretch. Every accepted input beat goes through a behavioural copy of
// the filter, and each residual beat is checked against the oldest prediction.
module lpc_residual_filter_core_tb;
  import lpcrf_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;

  localparam int ItemsPerPhase = 200;
  localparam int RandomPhases  = 8;
  localparam int HoldAtResult  = 40;
  localparam int LongHold      = 300;
  localparam int DrainCycles   = 40;
  localparam int CycleLimit    = 500_000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_data_o;

  // Beats waiting to be offered, and residuals waiting to come back.
  in_beat_t  pending_beats[$];
  out_beat_t expected_residuals[$];

  // Behavioural copy of the filter state.
  logic signed [DataW-1:0] coef_bank[TapsDef];
  logic signed [DataW-1:0] sample_history[TapsDef];

  int  errors       = 0;
  int  beats_queued = 0;
  int  cycle_count  = 0;
  bit  in_taken     = 1'b0;
  bit  out_taken    = 1'b0;

  lpc_residual_filter_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shifts a sample into the head of the delay line.
  function automatic void shift_history(input logic signed [DataW-1:0] sample);
    for (int k = TapsDef - 1; k > 0; k--) sample_history[k] = sample_history[k - 1];
    sample_history[0] = sample;
  endfunction

  // Applies one accepted beat to the state copy. Returns 1 when the beat
  // yields a residual, which is then given in res.
  function automatic bit filter_residual(input in_beat_t beat, output out_beat_t res);
    logic [DataW-1:0] acc;
    longint           prod;
    res = '0;
    case (beat.operation)
      OP_LOAD: begin
        // Tap numbers outside 1..TAPS leave the bank alone.
        if (beat.coef_index >= 1 && beat.coef_index <= TapsDef) begin
          coef_bank[beat.coef_index - 1] = beat.value;
        end
        return 1'b0;
      end
      OP_PUSH: begin
        shift_history(beat.value);
        return 1'b0;
      end
      OP_FILTER: begin
        // Each Q24 product is exact in 64 bits, shifted arithmetically and cut
        // to 32 bits; the running sum simply wraps.
        acc = beat.value;
        for (int k = 0; k < TapsDef; k++) begin
          prod = longint'(coef_bank[k]) * longint'(sample_history[k]);
          prod = prod >>> CoefFracBitsDef;
          acc  = acc + prod[DataW-1:0];
        end
        shift_history(beat.value);
        res.residual      = acc;
        res.last_of_frame = beat.frame_end;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Accepted input beats are predicted at the clock edge that takes them.
  always @(posedge clk_i) begin : take_input
    out_beat_t res;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) begin
      if (filter_residual(in_data_i, res)) expected_residuals.push_back(res);
      void'(pending_beats.pop_front());
    end
  end

  // Sender: offers the next queued beat after a random gap. A gap of zero keeps
  // valid high straight into the next beat. Now and then the sender switches
  // into a quiet mode with no gaps at all.
  always @(negedge clk_i) begin : drive_input
    logic   nxt_valid;
    int     send_gap;
    bit     quiet_tx;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_taken) begin
        nxt_valid = 1'b0;
        send_gap  = quiet_tx ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 59) == 0) quiet_tx = !quiet_tx;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_beats.size() != 0) begin
          nxt_valid = 1'b1;
          in_data_i <= pending_beats[0];
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // Receiver: after each residual beat it draws a stall. At one fixed point it
  // holds off for a long stretch instead, so that a finished residual sits in
  // the output register, the next filter beat parks behind it and the input
  // side has to stall.
  always @(negedge clk_i) begin : drive_output_ready
    int rx_wait;
    int results_seen;
    bit quiet_rx;
    if (rst_ni) begin
      if (out_taken) begin
        results_seen++;
        if (results_seen == HoldAtResult) begin
          rx_wait = LongHold;
        end else begin
          rx_wait = quiet_rx ? 0 : $urandom_range(0, 6);
        end
        if ($urandom_range(0, 59) == 0) quiet_rx = !quiet_rx;
      end
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker: every residual beat must match the oldest prediction.
  always @(posedge clk_i) begin : check_output
    out_beat_t want;
    out_taken = rst_ni && out_valid_o && out_ready_i;
    if (out_taken) begin
      if (expected_residuals.size() == 0) begin
        $error("residual beat %0d with no prediction waiting", out_data_o.residual);
        errors++;
      end else begin
        want = expected_residuals.pop_front();
        if (out_data_o.residual !== want.residual) begin
          $error("residual: expected %0d, got %0d", want.residual, out_data_o.residual);
          errors++;
        end
        if (out_data_o.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
                 out_data_o.last_of_frame);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Queues one beat. Beats that the block ignores are not counted.
  function automatic void add_beat(input logic [OpW-1:0] op, input int idx,
                                   input logic [DataW-1:0] val, input bit fe);
    in_beat_t beat;
    beat.operation  = op;
    beat.coef_index = IdxW'(idx);
    beat.value      = val;
    beat.frame_end  = fe;
    pending_beats.push_back(beat);
    if (op != OpUnused && !(op == OP_LOAD && (idx == 0 || idx > TapsDef))) beats_queued++;
  endfunction

  // Coefficients: half are realistic Q24 values within +-2.0, the rest full range.
  function automatic logic [DataW-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:          return 32'h7FFF_FFFF;
      1:          return 32'h8000_0000;
      2, 3, 4, 5: return 32'(int'($urandom_range(0, 2 ** 26)) - 2 ** 25);
      default:    return $urandom();
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'(int'($urandom_range(0, 2)) - 1);
      3, 4:    return 32'(int'($urandom_range(0, 65535)) - 32768);
      default: return $urandom();
    endcase
  endfunction

  // A well-formed frame: coefficient loads (sometimes the whole bank), a few
  // history pushes, then a run of filtered samples closed by frame_end.
  function automatic void add_frame();
    int n_load;
    int n_hist;
    int n_filt;
    n_load = ($urandom_range(0, 3) == 0) ? TapsDef : $urandom_range(0, 6);
    for (int i = 0; i < n_load; i++) begin
      add_beat(OP_LOAD, (n_load == TapsDef) ? i + 1 : $urandom_range(1, TapsDef),
               rand_coef(), 1'($urandom_range(0, 1)));
    end
    n_hist = $urandom_range(0, 4);
    for (int i = 0; i < n_hist; i++) begin
      add_beat(OP_PUSH, $urandom_range(0, 31), rand_sample(), 1'($urandom_range(0, 1)));
    end
    n_filt = $urandom_range(2, 20);
    for (int i = 0; i < n_filt; i++) begin
      add_beat(OP_FILTER, $urandom_range(0, 31), rand_sample(),
               (i == n_filt - 1) || ($urandom_range(0, 15) == 0));
    end
  endfunction

  // Noise: the unused operation, loads to tap numbers that do not exist, or
  // beats with every field random.
  function automatic void add_noise();
    case ($urandom_range(0, 2))
      0:       add_beat(OpUnused, $urandom_range(0, 31), $urandom(),
                        1'($urandom_range(0, 1)));
      1:       add_beat(OP_LOAD, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(TapsDef + 1, 31),
                        $urandom(), 1'($urandom_range(0, 1)));
      default: add_beat(OpW'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom(),
                        1'($urandom_range(0, 1)));
    endcase
  endfunction

  // Holds until every queued beat has gone in and every residual has come out.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || expected_residuals.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    foreach (coef_bank[k]) coef_bank[k] = '0;
    foreach (sample_history[k]) sample_history[k] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed run. With everything zero the residual is the sample itself.
    add_beat(OP_FILTER, 0, 32'h7FFF_FFFF, 1'b1);
    add_beat(OP_FILTER, 0, 32'h8000_0000, 1'b0);
    // Largest and smallest coefficients at the outer taps.
    add_beat(OP_LOAD, 1, 32'h7FFF_FFFF, 1'b0);
    add_beat(OP_LOAD, TapsDef, 32'h8000_0000, 1'b1);
    // Tap numbers that do not exist, and the unused operation, change nothing.
    add_beat(OP_LOAD, 0, 32'h1234_5678, 1'b0);
    add_beat(OP_LOAD, TapsDef + 1, 32'hFFFF_FFFF, 1'b1);
    add_beat(OP_LOAD, 31, 32'h7FFF_FFFF, 1'b0);
    add_beat(OpUnused, 31, 32'hFFFF_FFFF, 1'b1);
    // A pushed extreme sample times the largest coefficient drives the sum
    // far past the 32-bit range, so it must wrap.
    add_beat(OP_PUSH, 31, 32'h8000_0000, 1'b1);
    add_beat(OP_FILTER, 0, 32'h7FFF_FFFF, 1'b1);
    add_beat(OP_FILTER, 31, 32'hFFFF_FFFF, 1'b0);
    add_beat(OP_LOAD, 2, 32'h0100_0000, 1'b0);
    add_beat(OP_LOAD, 3, 32'hFF00_0000, 1'b0);
    add_beat(OP_PUSH, 0, 32'h7FFF_FFFF, 1'b0);
    add_beat(OP_PUSH, 0, 32'h0000_0000, 1'b1);
    add_beat(OP_FILTER, 0, 32'h0000_0001, 1'b1);
    add_beat(OP_FILTER, 0, 32'h8000_0000, 1'b1);
    add_beat(OP_LOAD, TapsDef, 32'h7FFF_FFFF, 1'b0);
    add_beat(OP_FILTER, 0, 32'h7FFF_FFFF, 1'b0);
    add_beat(OP_FILTER, 0, 32'h0000_0000, 1'b1);
    // The sender pauses here until all residuals are back.
    wait_drained();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      beats_queued = 0;
      while (beats_queued < ItemsPerPhase) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        else add_frame();
      end
      wait_drained();
    end

    // Give any stray beat time to show up before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
